// ----- hdl/dtt_pkg.sv -----
`timescale 1ns / 1ps
package dtt_pkg;

  localparam int unsigned DefaultSlots = 32;
  localparam int unsigned IdW = 5;
  localparam int unsigned TimeW = 32;
  localparam int unsigned WinW = 31;
  localparam logic [WinW-1:0] LazyWindowReset = 31'd300;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_DELETE = 3'd1,
    OP_QUERY  = 3'd2,
    OP_EXPIRE = 3'd3,
    OP_CANCEL = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_KEPT      = 3'd1,
    KIND_DELETED   = 3'd2,
    KIND_NOT_ARMED = 3'd3,
    KIND_REMAINING = 3'd4,
    KIND_EXPIRED   = 3'd5,
    KIND_CANCELLED = 3'd6,
    KIND_DONE      = 3'd7
  } kind_e;

  localparam logic [2:0] RegLazyWindow = 3'd0;

  typedef struct packed {
    logic [2:0]       op;
    logic [IdW-1:0]   timer_id;
    logic [TimeW-1:0] duration;
    logic [TimeW-1:0] now;
    logic             cancelable;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0]   timer_id_res;
    logic [2:0]       kind;
    logic [TimeW-1:0] remaining;
    logic             last;
  } rsp_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    op_e              op;
    logic [IdW-1:0]   slot;
    logic [TimeW-1:0] key;
    logic [TimeW-1:0] now;
    logic             cancelable;
  } cmd_t;

endpackage

// ----- hdl/deadline_timer_table_unit.sv -----
`timescale 1ns / 1ps
// Flow: add and delete results are registered in the execute state once the queued input
// transaction is taken. Query, expire and cancel first scan the table four slots a cycle,
// so their first result follows the scan, and each further expire or cancel result follows
// a fresh scan that starts after the previous one is taken. The back end holds one command
// at a time and takes the next only once its last result is taken. Reset: clears armed and
// cancelable flags, queue, window 300.
module deadline_timer_table_unit #(
  parameter int unsigned Slots = dtt_pkg::DefaultSlots
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  dtt_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output dtt_pkg::rsp_t rsp_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import dtt_pkg::*;

  // The lazy window lives here; only the user ensures writes happen while the block is idle.
  logic [WinW-1:0] lazy_window_q;
  logic            cmd_valid, cmd_ready;
  cmd_t            cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == RegLazyWindow) ? {1'b0, lazy_window_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lazy_window_q <= LazyWindowReset;
    end else if (psel && penable && pwrite && paddr == RegLazyWindow) begin
      lazy_window_q <= pwdata[WinW-1:0];
    end
  end

  // The front end classifies each transaction and queues it for the table.
  dtt_front #(.Slots(Slots)) u_front (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  // The back end owns the table and emits one result transaction at a time.
  dtt_back #(.Slots(Slots)) u_back (
    .clk_i, .rst_ni, .lazy_window_i(lazy_window_q),
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .rsp_valid_o, .rsp_ready_i, .rsp_o
  );

endmodule

// ----- hdl/dtt_front.sv -----
`timescale 1ns / 1ps
module dtt_front #(
  parameter int unsigned Slots = dtt_pkg::DefaultSlots
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  dtt_pkg::req_t req_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output dtt_pkg::cmd_t cmd_o
);
  import dtt_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  cmd_t              mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  cmd_t              cmd_new;
  logic              known_op, push, pop;
  logic [IdW-1:0]    slot_w;

  always_comb begin
    slot_w = req_i.timer_id;
    if (Slots < 32) begin
      // Restoring reduction modulo Slots, one compare and subtract per bit.
      for (int s = IdW - 1; s >= 0; s--) begin
        if (32'(slot_w) >= (Slots << s)) begin
          slot_w = IdW'(32'(slot_w) - (Slots << s));
        end
      end
    end
  end

  assign known_op = (req_i.op <= 3'(OP_CANCEL));

  always_comb begin
    cmd_new.op         = op_e'(req_i.op);
    cmd_new.slot       = slot_w;
    cmd_new.key        = req_i.now + req_i.duration;
    cmd_new.now        = req_i.now;
    cmd_new.cancelable = req_i.cancelable;
  end

  assign req_ready_o = (cnt_q != (PtrW+1)'(QueueDepth));
  // Unknown operations are accepted and dropped here.
  assign push = req_valid_i && req_ready_o && known_op;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push) wr_d = (32'(wr_q) == QueueDepth - 1) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (32'(rd_q) == QueueDepth - 1) ? '0 : rd_q + 1'b1;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cmd_new;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QueueDepth)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != '0) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");

endmodule

// ----- hdl/dtt_back.sv -----
`timescale 1ns / 1ps
module dtt_back #(
  parameter int unsigned Slots = dtt_pkg::DefaultSlots
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [dtt_pkg::WinW-1:0] lazy_window_i,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  dtt_pkg::cmd_t         cmd_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output dtt_pkg::rsp_t         rsp_o
);
  import dtt_pkg::*;

  localparam int unsigned SW = (Slots > 1) ? $clog2(Slots) : 1;
  // Slots examined per cycle of the earliest-deadline scan.
  localparam int unsigned Lanes = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_OUT
  } state_e;

  state_e           state_q;
  cmd_t             cmd_q;
  logic [Slots-1:0] armed_q, cancel_ok_q;
  logic [TimeW-1:0] deadline_q [Slots];
  rsp_t             rsp_q, rsp_d;
  logic             rsp_valid_q;
  logic             more_q, more_d;   // loop continues after the pending result

  // Running earliest search in ascending slot order; a later slot wins only when
  // strictly earlier, so ties go to the lowest slot.
  logic [SW:0]      scan_q;
  logic             found_q, found_d;
  logic [SW-1:0]    best_q, best_d;
  logic [TimeW-1:0] best_dl_q, best_dl_d;
  logic [SW:0]      lane_idx;
  logic [TimeW-1:0] lane_dl;
  logic             scan_done;

  always_comb begin
    found_d   = found_q;
    best_d    = best_q;
    best_dl_d = best_dl_q;
    lane_idx  = scan_q;
    lane_dl   = '0;
    for (int l = 0; l < Lanes; l++) begin
      lane_idx = scan_q + (SW+1)'(l);
      if (32'(lane_idx) < Slots && armed_q[lane_idx[SW-1:0]]) begin
        lane_dl = deadline_q[lane_idx[SW-1:0]];
        if (!found_d || ((lane_dl - best_dl_d) >> (TimeW-1)) != '0) begin
          best_d    = lane_idx[SW-1:0];
          best_dl_d = lane_dl;
        end
        found_d = 1'b1;
      end
    end
  end

  assign scan_done = (32'(scan_q) + Lanes >= Slots);

  logic [SW-1:0]    slot;
  logic [TimeW-1:0] diff_key, mag, diff_now;
  logic             lazy, due, pop_hit;

  assign slot     = SW'(cmd_q.slot);
  assign diff_key = cmd_q.key - deadline_q[slot];
  assign mag      = diff_key[TimeW-1] ? (TimeW'(0) - diff_key) : diff_key;
  assign lazy     = armed_q[slot] && (mag < {1'b0, lazy_window_i});
  assign diff_now = best_dl_q - cmd_q.now;
  assign due      = (diff_now == '0) || diff_now[TimeW-1];
  assign pop_hit  = found_q && ((cmd_q.op == OP_EXPIRE) ? due : cancel_ok_q[best_q]);

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    rsp_d.timer_id_res = IdW'(slot);
    rsp_d.kind         = KIND_DONE;
    rsp_d.remaining    = '0;
    rsp_d.last         = 1'b1;
    more_d             = 1'b0;
    unique case (cmd_q.op)
      OP_ADD:    rsp_d.kind = lazy ? KIND_KEPT : KIND_ADDED;
      OP_DELETE: rsp_d.kind = armed_q[slot] ? KIND_DELETED : KIND_NOT_ARMED;
      OP_QUERY: begin
        rsp_d.kind = KIND_REMAINING;
        if (!found_q) begin
          rsp_d.timer_id_res = '0;
          rsp_d.remaining    = '1;
        end else begin
          rsp_d.timer_id_res = IdW'(best_q);
          rsp_d.remaining    = diff_now[TimeW-1] ? '0 : diff_now;
        end
      end
      OP_EXPIRE, OP_CANCEL: begin
        if (pop_hit) begin
          rsp_d.timer_id_res = IdW'(best_q);
          rsp_d.kind = (cmd_q.op == OP_EXPIRE) ? KIND_EXPIRED : KIND_CANCELLED;
          rsp_d.last = 1'b0;
          more_d     = 1'b1;
        end else begin
          rsp_d.timer_id_res = '0;
          rsp_d.kind         = KIND_DONE;
        end
      end
      default: rsp_d.kind = KIND_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      armed_q     <= '0;
      cancel_ok_q <= '0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
      more_q      <= 1'b0;
      scan_q      <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      best_dl_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            scan_q  <= '0;
            found_q <= 1'b0;
            state_q <= (cmd_i.op == OP_ADD || cmd_i.op == OP_DELETE) ? ST_EXEC : ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_q    <= scan_q + (SW+1)'(Lanes);
          found_q   <= found_d;
          best_q    <= best_d;
          best_dl_q <= best_dl_d;
          if (scan_done) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          unique case (cmd_q.op)
            OP_ADD: begin
              cancel_ok_q[slot] <= cmd_q.cancelable;
              if (!lazy) armed_q[slot] <= 1'b1;
            end
            OP_DELETE: armed_q[slot] <= 1'b0;
            OP_EXPIRE, OP_CANCEL: begin
              if (pop_hit) armed_q[best_q] <= 1'b0;
            end
            default: ;
          endcase
          rsp_q       <= rsp_d;
          more_q      <= more_d;
          rsp_valid_q <= 1'b1;
          state_q     <= ST_OUT;
        end
        ST_OUT: begin
          if (rsp_ready_i) begin
            rsp_valid_q <= 1'b0;
            scan_q      <= '0;
            found_q     <= 1'b0;
            state_q     <= more_q ? ST_SCAN : ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC && cmd_q.op == OP_ADD && !lazy) deadline_q[slot] <= cmd_q.key;
  end

  a_valid_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> state_q == ST_OUT) else $error("result outside output state");
  a_more_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (more_q == !rsp_q.last)) else $error("last flag mismatch");
  a_pop_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && more_q) |-> !armed_q[SW'(rsp_q.timer_id_res)])
    else $error("popped slot still armed");

endmodule
